// ===== rtl/core/tts_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tts_pkg
// Shared types and constants for the two-tier ordered stack.
// ----------------------------------------------------------------------------
package tts_pkg;

    localparam int DEF_LAYER_DEPTH   = 32;
    localparam int DEF_OVERLAY_DEPTH = 32;
    localparam int DEF_VALUE_WIDTH   = 32;
    localparam int OP_W              = 3;
    localparam int OUT_W             = 32;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_LAYER     = 3'd0,
        OP_PUSH_OVERLAY   = 3'd1,
        OP_REMOVE_LAYER   = 3'd2,
        OP_REMOVE_OVERLAY = 3'd3,
        OP_ITERATE        = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_SHIFT,
        ST_IT_RD,
        ST_IT_LD
    } state_t;

    typedef struct packed {
        state_t state;
        logic   pend;
    } tts_status_t;

endpackage
`default_nettype wire

// ===== rtl/core/tts_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tts_ram
// Single write port, single registered read port list storage.
// ----------------------------------------------------------------------------
module tts_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 32,
    parameter int AW    = 5
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

// ===== rtl/core/tts_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tts_ctrl
// Sequencer: list counts, push, search-and-compact remove, iterate, output reg.
// ----------------------------------------------------------------------------
module tts_ctrl #(
    parameter int LAYER_DEPTH   = 32,
    parameter int OVERLAY_DEPTH = 32,
    parameter int VALUE_WIDTH   = 32,
    parameter int LAW           = 5,
    parameter int OAW           = 5
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [tts_pkg::OP_W-1:0]      s_op,
    input  wire logic signed [tts_pkg::OUT_W-1:0] s_item_value,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic signed [tts_pkg::OUT_W-1:0]   m_out_value,
    output logic                               m_from_overlay,
    output logic                               m_last_item,
    output logic                               lay_wr_en,
    output logic [LAW-1:0]                     lay_wr_addr,
    output logic [LAW-1:0]                     lay_rd_addr,
    input  wire logic [VALUE_WIDTH-1:0]        lay_rd_data,
    output logic                               ovl_wr_en,
    output logic [OAW-1:0]                     ovl_wr_addr,
    output logic [OAW-1:0]                     ovl_rd_addr,
    input  wire logic [VALUE_WIDTH-1:0]        ovl_rd_data,
    output logic [VALUE_WIDTH-1:0]             wr_data,
    output tts_pkg::tts_status_t               status
);
    import tts_pkg::*;

    localparam int MAXD = (LAYER_DEPTH > OVERLAY_DEPTH) ? LAYER_DEPTH : OVERLAY_DEPTH;
    localparam int IW   = (MAXD > 1) ? $clog2(MAXD) : 1;
    localparam int CW   = $clog2(MAXD + 1);
    localparam int XW   = (VALUE_WIDTH > OUT_W) ? VALUE_WIDTH : OUT_W;

    state_t                   state_reg, state_next;
    logic                     sel_reg, sel_next;
    logic [VALUE_WIDTH-1:0]   key_reg, key_next;
    logic [CW-1:0]            lay_cnt_reg, lay_cnt_next;
    logic [CW-1:0]            ovl_cnt_reg, ovl_cnt_next;
    logic [CW-1:0]            idx_reg, idx_next;
    logic [IW-1:0]            pos_reg, pos_next;
    logic                     pend_reg, pend_next;
    logic                     out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]         out_value_reg, out_value_next;
    logic                     out_ovl_reg, out_ovl_next;
    logic                     out_last_reg, out_last_next;

    logic [XW-1:0]            in_x;
    logic [VALUE_WIDTH-1:0]   in_key;
    logic [VALUE_WIDTH-1:0]   rd_sel;
    logic signed [VALUE_WIDTH-1:0] rd_s;
    logic signed [XW-1:0]     rd_x;
    logic [CW-1:0]            cnt_sel;
    logic [CW-1:0]            idx_dec;
    logic                     hit;
    logic [IW-1:0]            wr_addr_i;
    logic                     we_i;

    assign in_x    = XW'($unsigned(s_item_value));
    assign in_key  = in_x[VALUE_WIDTH-1:0];
    assign rd_sel  = sel_reg ? ovl_rd_data : lay_rd_data;
    assign rd_s    = $signed(rd_sel);
    assign rd_x    = XW'(rd_s);
    assign cnt_sel = sel_reg ? ovl_cnt_reg : lay_cnt_reg;
    assign idx_dec = idx_reg - CW'(1);
    assign hit     = pend_reg && (rd_sel == key_reg);

    assign lay_wr_en   = we_i && !sel_next;
    assign ovl_wr_en   = we_i && sel_next;
    assign lay_wr_addr = wr_addr_i[LAW-1:0];
    assign ovl_wr_addr = wr_addr_i[OAW-1:0];
    assign lay_rd_addr = idx_reg[LAW-1:0];
    assign ovl_rd_addr = idx_reg[OAW-1:0];

    assign s_ready        = (state_reg == ST_IDLE);
    assign m_valid        = out_valid_reg;
    assign m_out_value    = $signed(out_value_reg);
    assign m_from_overlay = out_ovl_reg;
    assign m_last_item    = out_last_reg;
    assign status.state   = state_reg;
    assign status.pend    = pend_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            lay_cnt_reg   <= '0;
            ovl_cnt_reg   <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            lay_cnt_reg   <= lay_cnt_next;
            ovl_cnt_reg   <= ovl_cnt_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        sel_reg       <= sel_next;
        key_reg       <= key_next;
        idx_reg       <= idx_next;
        pos_reg       <= pos_next;
        out_value_reg <= out_value_next;
        out_ovl_reg   <= out_ovl_next;
        out_last_reg  <= out_last_next;
    end

    always_comb begin
        state_next     = state_reg;
        sel_next       = sel_reg;
        key_next       = key_reg;
        lay_cnt_next   = lay_cnt_reg;
        ovl_cnt_next   = ovl_cnt_reg;
        idx_next       = idx_reg;
        pos_next       = pos_reg;
        pend_next      = pend_reg;
        out_valid_next = out_valid_reg;
        out_value_next = out_value_reg;
        out_ovl_next   = out_ovl_reg;
        out_last_next  = out_last_reg;
        we_i           = 1'b0;
        wr_addr_i      = pos_reg;
        wr_data        = rd_sel;

        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    case (s_op)
                        OP_PUSH_LAYER: begin
                            sel_next = 1'b0;
                            if (lay_cnt_reg < CW'(LAYER_DEPTH)) begin
                                we_i         = 1'b1;
                                wr_addr_i    = lay_cnt_reg[IW-1:0];
                                wr_data      = in_key;
                                lay_cnt_next = lay_cnt_reg + CW'(1);
                            end
                        end
                        OP_PUSH_OVERLAY: begin
                            sel_next = 1'b1;
                            if (ovl_cnt_reg < CW'(OVERLAY_DEPTH)) begin
                                we_i         = 1'b1;
                                wr_addr_i    = ovl_cnt_reg[IW-1:0];
                                wr_data      = in_key;
                                ovl_cnt_next = ovl_cnt_reg + CW'(1);
                            end
                        end
                        OP_REMOVE_LAYER, OP_REMOVE_OVERLAY: begin
                            sel_next   = (s_op == OP_REMOVE_OVERLAY);
                            key_next   = in_key;
                            idx_next   = '0;
                            pend_next  = 1'b0;
                            state_next = ST_SEARCH;
                        end
                        OP_ITERATE: begin
                            if (ovl_cnt_reg != '0) begin
                                sel_next   = 1'b1;
                                idx_next   = ovl_cnt_reg - CW'(1);
                                state_next = ST_IT_RD;
                            end else if (lay_cnt_reg != '0) begin
                                sel_next   = 1'b0;
                                idx_next   = lay_cnt_reg - CW'(1);
                                state_next = ST_IT_RD;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_SEARCH: begin
                if (hit) begin
                    idx_next   = CW'(pos_reg) + CW'(1);
                    pend_next  = 1'b0;
                    state_next = ST_SHIFT;
                end else if (idx_reg < cnt_sel) begin
                    pend_next = 1'b1;
                    pos_next  = idx_reg[IW-1:0];
                    idx_next  = idx_reg + CW'(1);
                end else begin
                    pend_next  = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            ST_SHIFT: begin
                // word read last cycle lands one slot lower
                we_i = pend_reg;
                if (idx_reg < cnt_sel) begin
                    pend_next = 1'b1;
                    pos_next  = idx_dec[IW-1:0];
                    idx_next  = idx_reg + CW'(1);
                end else begin
                    pend_next  = 1'b0;
                    state_next = ST_IDLE;
                    if (sel_reg) begin
                        ovl_cnt_next = ovl_cnt_reg - CW'(1);
                    end else begin
                        lay_cnt_next = lay_cnt_reg - CW'(1);
                    end
                end
            end
            ST_IT_RD: begin
                if (!out_valid_reg || m_ready) begin
                    state_next = ST_IT_LD;
                end
            end
            ST_IT_LD: begin
                out_valid_next = 1'b1;
                out_value_next = rd_x[OUT_W-1:0];
                out_ovl_next   = sel_reg;
                out_last_next  = (idx_reg == '0) && (!sel_reg || lay_cnt_reg == '0);
                if (idx_reg != '0) begin
                    idx_next   = idx_dec;
                    state_next = ST_IT_RD;
                end else if (sel_reg && lay_cnt_reg != '0) begin
                    sel_next   = 1'b0;
                    idx_next   = lay_cnt_reg - CW'(1);
                    state_next = ST_IT_RD;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/core/two_tier_ordered_stack.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// two_tier_ordered_stack
// Two ordered value lists (layers, overlays) with push, remove and iterate.
//
// Input channel s_valid/s_ready carries s_op and s_item_value. Output channel
// m_valid/m_ready carries one word per stored value during iterate:
// m_out_value, m_from_overlay and m_last_item on the final word.
// Push: the block stays ready after a push; a push to a full list
// is dropped. Remove: a pipelined search through the chosen list, one entry
// per cycle, then a compaction of the entries above the match, one per
// cycle. Iterate: each word takes a RAM read, then an output register load;
// overlays newest first, then layers newest first; nothing is emitted with
// both lists empty. s_ready is low while remove or iterate runs.
// A stalled receiver holds the output register and pauses iterate.
// Reset clears both counts and the output valid flag; list contents are kept.
// ----------------------------------------------------------------------------
module two_tier_ordered_stack #(
    parameter int LAYER_DEPTH   = tts_pkg::DEF_LAYER_DEPTH,
    parameter int OVERLAY_DEPTH = tts_pkg::DEF_OVERLAY_DEPTH,
    parameter int VALUE_WIDTH   = tts_pkg::DEF_VALUE_WIDTH
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic [tts_pkg::OP_W-1:0]         s_op,
    input  wire logic signed [tts_pkg::OUT_W-1:0] s_item_value,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic signed [tts_pkg::OUT_W-1:0]      m_out_value,
    output logic                                  m_from_overlay,
    output logic                                  m_last_item
);
    import tts_pkg::*;

    localparam int LAW = (LAYER_DEPTH > 1) ? $clog2(LAYER_DEPTH) : 1;
    localparam int OAW = (OVERLAY_DEPTH > 1) ? $clog2(OVERLAY_DEPTH) : 1;

    logic                   lay_wr_en, ovl_wr_en;
    logic [LAW-1:0]         lay_wr_addr, lay_rd_addr;
    logic [OAW-1:0]         ovl_wr_addr, ovl_rd_addr;
    logic [VALUE_WIDTH-1:0] lay_rd_data, ovl_rd_data, wr_data;
    tts_status_t            status;

    tts_ram #(
        .DEPTH (LAYER_DEPTH),
        .WIDTH (VALUE_WIDTH),
        .AW    (LAW)
    ) u_layer_ram (
        .aclk    (aclk),
        .wr_en   (lay_wr_en),
        .wr_addr (lay_wr_addr),
        .wr_data (wr_data),
        .rd_addr (lay_rd_addr),
        .rd_data (lay_rd_data)
    );

    tts_ram #(
        .DEPTH (OVERLAY_DEPTH),
        .WIDTH (VALUE_WIDTH),
        .AW    (OAW)
    ) u_overlay_ram (
        .aclk    (aclk),
        .wr_en   (ovl_wr_en),
        .wr_addr (ovl_wr_addr),
        .wr_data (wr_data),
        .rd_addr (ovl_rd_addr),
        .rd_data (ovl_rd_data)
    );

    tts_ctrl #(
        .LAYER_DEPTH   (LAYER_DEPTH),
        .OVERLAY_DEPTH (OVERLAY_DEPTH),
        .VALUE_WIDTH   (VALUE_WIDTH),
        .LAW           (LAW),
        .OAW           (OAW)
    ) u_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_op           (s_op),
        .s_item_value   (s_item_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_value    (m_out_value),
        .m_from_overlay (m_from_overlay),
        .m_last_item    (m_last_item),
        .lay_wr_en      (lay_wr_en),
        .lay_wr_addr    (lay_wr_addr),
        .lay_rd_addr    (lay_rd_addr),
        .lay_rd_data    (lay_rd_data),
        .ovl_wr_en      (ovl_wr_en),
        .ovl_wr_addr    (ovl_wr_addr),
        .ovl_rd_addr    (ovl_rd_addr),
        .ovl_rd_data    (ovl_rd_data),
        .wr_data        (wr_data),
        .status         (status)
    );

    // output register is free whenever a new word is loaded
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (status.state == ST_IT_LD) |-> !m_valid)
        else $error("output word overwritten");

    a_valid_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> ($past(status.state) == ST_IT_LD))
        else $error("output word without load");

    a_pend_ctx: assert property (@(posedge aclk) disable iff (!aresetn)
        status.pend |-> (status.state == ST_SEARCH || status.state == ST_SHIFT))
        else $error("pending read outside remove");

endmodule
`default_nettype wire
